### rtl/core/wbps_pkg.sv
// wbps_pkg: shared types and constants of the wildcard byte pattern search
// holds beat payload structs, register index codes and the controller status struct
// no dependencies
package wbps_pkg;

   localparam int LEN_W    = 5;
   localparam int IDX_W    = 3;
   localparam int CSR_W    = 64;
   localparam int MOFF_W   = 32;
   localparam int PAT_W    = 64;
   localparam int CARE_W   = 16;
   localparam int START_W  = 32;

   localparam logic [IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [IDX_W-1:0] REG_CARE_MASK    = 3'd2;
   localparam logic [IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [IDX_W-1:0] REG_START_OFFSET = 3'd4;

   localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic              found;
      logic [MOFF_W-1:0] match_offset;
   } rsp_payload_type;

   typedef struct packed {
      logic              eligible;
      logic              done;
      logic [MOFF_W-1:0] cand_offset;
   } pos_status_type;

endpackage

### rtl/core/wildcard_byte_pattern_search_top.sv
// wildcard_byte_pattern_search_top: masked byte pattern search over a byte stream
// depends on wbps_pkg, wbps_cell and wbps_pos
//
// Usage:
//   req channel: one buffer byte per beat (req_payload), last_byte marks the end of
//   the buffer. rsp channel: one beat per buffer, found plus the offset of the
//   first match at or after start_offset, or found = 0 with offset 0 at the last
//   byte when nothing matched. Bytes after a match are absorbed without a beat.
//   csr port: plain writes of pattern low/high, care mask, pattern length and start
//   offset, done only while no buffer is in flight.
//   Throughput: one byte per cycle unless stalled. Every byte shifts through a
//   row of MAX_PATTERN_BYTES window cells that each compare their byte in parallel.
//   Result: the beat is registered and shows on rsp in the cycle after the byte
//   that ends or matches the buffer is taken.
//   Stall: a valid result holds while rsp_stall is high; req_stall is raised
//   only while a result is held and stalled, so bytes keep flowing otherwise.
//   Reset: registers go to pattern 0, care mask all ones, length 1, start 0, and
//   the window, position and match state clear.
module wildcard_byte_pattern_search_top import wbps_pkg::*; #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   logic [PAT_W-1:0]   pat_low_ff;
   logic [PAT_W-1:0]   pat_high_ff;
   logic [CARE_W-1:0]  care_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [START_W-1:0] start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= CARE_RESET;
         len_ff      <= LEN_RESET;
         start_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
            REG_PATTERN_HIGH: pat_high_ff <= csr_write_data;
            REG_CARE_MASK:    care_ff     <= csr_write_data[CARE_W-1:0];
            REG_PATTERN_LEN:  len_ff      <= csr_write_data[LEN_W-1:0];
            REG_START_OFFSET: start_ff    <= csr_write_data[START_W-1:0];
            default: ;
         endcase
      end
   end

   // zero length acts as one, long lengths clamp to the cell count
   logic [LEN_W-1:0]       len_eff;
   logic [2*PAT_W-1:0]     pat_word;
   logic                   advance;
   logic                   all_hit;
   logic [MAX_PATTERN_BYTES-1:0] cell_hit;
   logic [7:0]             win [MAX_PATTERN_BYTES];
   pos_status_type         status;

   always_comb begin
      len_eff = len_ff;
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_PATTERN_BYTES)) begin
         len_eff = LEN_W'(MAX_PATTERN_BYTES);
      end
   end

   assign pat_word = {pat_high_ff, pat_low_ff};
   assign advance  = req_valid && !req_stall;
   assign all_hit  = &cell_hit;

   // cell k compares the byte k beats old against pattern byte len-1-k
   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      logic [LEN_W-1:0] pidx;
      logic             active;
      logic [7:0]       src;

      assign pidx   = len_eff - LEN_W'(1) - LEN_W'(k);
      assign active = LEN_W'(k) < len_eff;
      if (k == 0) begin : g_head
         assign src = req_payload.data_byte;
      end else begin : g_body
         assign src = win[k-1];
      end

      wbps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .clear     (req_payload.last_byte),
         .prev_byte (src),
         .pat_byte  (pat_word[pidx[3:0]*8 +: 8]),
         .care      (active && care_ff[pidx[3:0]]),
         .byte_out  (win[k]),
         .hit       (cell_hit[k])
      );
   end

   wbps_pos #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .last         (req_payload.last_byte),
      .hit          (all_hit),
      .len          (len_eff),
      .start_offset (start_ff),
      .status       (status)
   );

   logic            match_now;
   logic            produce;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   assign match_now = status.eligible && all_hit;
   assign produce   = match_now || (req_payload.last_byte && !status.done);
   assign req_stall = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in             = advance && produce;
         rsp_data_in.found        = match_now;
         rsp_data_in.match_offset = match_now ? status.cand_offset : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_miss_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |-> rsp_data_ff.match_offset == '0)
      else $error("not-found beat carries a nonzero offset");

   a_no_beat_after_match: assert property (@(posedge clock) disable iff (reset)
      advance && status.done |=> !rsp_valid_ff)
      else $error("second result beat in one buffer");

   a_last_clears_done: assert property (@(posedge clock) disable iff (reset)
      advance && req_payload.last_byte |=> !status.done)
      else $error("match state survived the end of a buffer");

endmodule

### rtl/core/wbps_cell.sv
// wbps_cell: one byte of the search window with its masked compare
// shifts the byte from its neighbor on each accepted beat; uses nothing from the package
module wbps_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       clear,
   input  logic [7:0] prev_byte,
   input  logic [7:0] pat_byte,
   input  logic       care,
   output logic [7:0] byte_out,
   output logic       hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // compare against the value this cell takes on the current beat
   assign hit = !care || (prev_byte == pat_byte);

   always_comb begin
      byte_in = byte_ff;
      if (advance) begin
         byte_in = clear ? 8'd0 : prev_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

### rtl/core/wbps_pos.sv
// wbps_pos: byte position counter and per-buffer match tracking
// depends on wbps_pkg for the status struct and field widths
module wbps_pos import wbps_pkg::*; #(
   parameter int OFFSET_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               last,
   input  logic               hit,
   input  logic [LEN_W-1:0]   len,
   input  logic [START_W-1:0] start_offset,
   output pos_status_type     status
);

   localparam int W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] pos_in;
   logic                   done_ff;
   logic                   done_in;
   logic [W-1:0]           pos_ext;
   logic [W-1:0]           len_m1;
   logic [W-1:0]           cand;
   logic                   sat;
   logic                   eligible;

   assign sat      = (pos_ff == {OFFSET_BITS{1'b1}});
   assign pos_ext  = W'(pos_ff);
   assign len_m1   = W'(len - LEN_W'(1));
   assign cand     = pos_ext - len_m1;
   assign eligible = !done_ff && !sat && (pos_ext >= len_m1) && (cand >= W'(start_offset));

   assign status.eligible    = eligible;
   assign status.done        = done_ff;
   assign status.cand_offset = cand[MOFF_W-1:0];

   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      if (advance) begin
         if (last) begin
            pos_in  = '0;
            done_in = 1'b0;
         end else begin
            pos_in  = sat ? pos_ff : pos_ff + OFFSET_BITS'(1);
            done_in = done_ff || (eligible && hit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

endmodule

### verif/wbps_checker.sv
`timescale 1ns / 100ps
// wbps_checker: result checker for wildcard_byte_pattern_search_top
// follows csr writes, predicts the single result of each buffer and compares rsp beats
// depends on wbps_pkg
module wbps_checker import wbps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_payload_type  req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_payload_type  rsp_payload,
   input  logic             csr_write_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_write_data,
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               match_count
);

   localparam int WINDOW_BYTES = 16;
   localparam int POS_W        = 32;

   logic [PAT_W-1:0]   pat_low;
   logic [PAT_W-1:0]   pat_high;
   logic [CARE_W-1:0]  care;
   logic [LEN_W-1:0]   len_reg;
   logic [START_W-1:0] start_at;

   logic [7:0]         window [WINDOW_BYTES];
   logic [POS_W-1:0]   position;
   logic               matched;
   rsp_payload_type    search_results [$];

   function automatic void clear_buffer();
      int k;
      for (k = 0; k < WINDOW_BYTES; k++) window[k] = 8'h00;
      position = '0;
      matched  = 1'b0;
   endfunction

   // one byte of the buffer: shift the window, try the candidate that ends here
   function automatic void scan_byte(input req_payload_type beat);
      int unsigned      plen;
      int               k;
      int               j;
      logic [127:0]     pattern;
      logic [POS_W-1:0] cand;
      logic             hit;
      plen = (len_reg == 0) ? 1 : (len_reg > WINDOW_BYTES) ? WINDOW_BYTES : len_reg;
      pattern = {pat_high, pat_low};
      for (k = WINDOW_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = beat.data_byte;

      // a saturated position no longer compares
      if (!matched && position != '1 && position >= plen - 1) begin
         cand = position - (plen - 1);
         if (cand >= start_at) begin
            hit = 1'b1;
            for (j = 0; j < plen; j++) begin
               if (care[j] && window[plen-1-j] != pattern[j*8 +: 8]) hit = 1'b0;
            end
            if (hit) begin
               search_results.push_back('{found: 1'b1, match_offset: cand});
               matched = 1'b1;
            end
         end
      end
      if (position != '1) position++;

      if (beat.last_byte) begin
         if (!matched) search_results.push_back('{found: 1'b0, match_offset: '0});
         clear_buffer();
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         pat_low  = '0;
         pat_high = '0;
         care     = CARE_RESET;
         len_reg  = LEN_RESET;
         start_at = '0;
         clear_buffer();
         search_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_PATTERN_LOW:  pat_low  = csr_write_data;
               REG_PATTERN_HIGH: pat_high = csr_write_data;
               REG_CARE_MASK:    care     = csr_write_data[CARE_W-1:0];
               REG_PATTERN_LEN:  len_reg  = csr_write_data[LEN_W-1:0];
               REG_START_OFFSET: start_at = csr_write_data[START_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) scan_byte(req_payload);

         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (search_results.size() == 0) begin
               $display("%0t: rsp beat with nothing expected, got found %0b offset %0d",
                        $time, rsp_payload.found, rsp_payload.match_offset);
               fail_count++;
            end else begin
               want = search_results.pop_front();
               if (want.found) match_count++;
               if (rsp_payload.found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, want.found, rsp_payload.found);
                  fail_count++;
               end
               if (rsp_payload.match_offset !== want.match_offset) begin
                  $display("%0t: match_offset mismatch, expected %0d, got %0d",
                           $time, want.match_offset, rsp_payload.match_offset);
                  fail_count++;
               end
            end
         end
      end
      pending = search_results.size();
   end

endmodule

### verif/tb_wildcard_byte_pattern_search_top.sv
`timescale 1ns / 100ps
// tb_wildcard_byte_pattern_search_top: stimulus and verdict for the byte pattern search
// drives buffers, csr settings and rsp stalls; wbps_checker predicts and compares
// depends on wbps_pkg, wbps_checker and wildcard_byte_pattern_search_top
module tb_wildcard_byte_pattern_search_top import wbps_pkg::*; ();

   localparam int HOLD_CYCLES  = 60;
   localparam int TARGET_BYTES = 550;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_payload_type  req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_payload_type  rsp_payload;
   logic             csr_write_en;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_write_data;

   int fail_count;
   int pending;
   int checked;
   int match_count;
   int bytes_sent;
   int buffers_sent;
   int settings_used;
   bit no_idle;
   bit hold_off;

   // current pattern, kept only to plant matches in the stimulus
   logic [127:0] cur_pattern;
   logic [15:0]  cur_care;
   int           cur_len;

   wildcard_byte_pattern_search_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   wbps_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked),
      .match_count    (match_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, or one long counted hold when asked
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 28);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      while (!no_idle && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: data, last_byte: last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (last) buffers_sent++;
      @(negedge clock);
   endtask

   // drop valid, let every pending result drain, then keep idling to settle absorbed bytes
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic write_config(input logic [63:0] low, input logic [63:0] high,
                               input logic [15:0] care, input logic [4:0] len,
                               input logic [31:0] start);
      wait_idle();
      csr_write(REG_PATTERN_LOW, low);
      csr_write(REG_PATTERN_HIGH, high);
      csr_write(REG_CARE_MASK, {48'd0, care});
      csr_write(REG_PATTERN_LEN, {59'd0, len});
      csr_write(REG_START_OFFSET, {32'd0, start});
      csr_write_en <= 1'b0;
      cur_pattern = {high, low};
      cur_care    = care;
      cur_len     = (len == 0) ? 1 : (len > 16) ? 16 : len;
      settings_used++;
   endtask

   // planted buffers carry the pattern (wildcards random) at a random spot,
   // possibly cut off by the end of the buffer
   task automatic send_buffer(input int blen, input bit planted);
      logic [7:0] bytes [$];
      int         at;
      int         j;
      bit         from_pattern;
      from_pattern = planted && $urandom_range(1);
      for (j = 0; j < blen; j++)
         bytes.push_back(from_pattern ? cur_pattern[$urandom_range(15)*8 +: 8] : 8'($urandom));
      if (planted) begin
         at = $urandom_range(blen - 1);
         for (j = 0; j < cur_len && at + j < blen; j++)
            if (cur_care[j]) bytes[at+j] = cur_pattern[j*8 +: 8];
      end
      for (j = 0; j < blen; j++) send_byte(bytes[j], j == blen - 1);
   endtask

   function automatic logic [63:0] pattern_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0] care;
      logic [4:0]  len;
      logic [31:0] start;
      int          blen;
      bit          pressure_done;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      csr_write_en   = 1'b0;
      csr_index      = REG_PATTERN_LOW;
      csr_write_data = '0;
      no_idle        = 1'b0;
      hold_off       = 1'b0;
      pressure_done  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one cared byte of value zero
      send_byte(8'hAB, 1'b0);
      send_byte(8'h00, 1'b1);

      // zero length acts as one byte; no care bits match anything, rest is absorbed
      write_config(64'hFF, '0, 16'h0000, 5'd0, 32'd0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b1);

      // oversized length saturates to 16, so a two byte buffer is too short
      write_config('1, '1, 16'h0000, 5'd31, 32'd0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);

      // start offset past any buffer
      write_config('0, '0, 16'hFFFF, 5'd1, 32'hFFFF_FFFF);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);

      // first hit lies below the start offset, the next one completes on the last byte
      write_config(64'h00FF, '1, 16'h8001, 5'd2, 32'd1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      while (bytes_sent < TARGET_BYTES) begin
         if (!pressure_done && bytes_sent > 250) begin
            // every single-byte buffer matches while rsp is held, so req backs up
            pressure_done = 1'b1;
            write_config('0, '0, 16'h0000, 5'd1, 32'd0);
            no_idle  = 1'b1;
            hold_off = 1'b1;
            repeat (24) send_byte(8'($urandom), 1'b1);
            no_idle = 1'b0;
         end
         no_idle = (bytes_sent >= 350 && bytes_sent < 470);

         case ($urandom_range(7))
            0:       care = 16'h0000;
            1:       care = 16'hFFFF;
            default: care = 16'($urandom);
         endcase
         case ($urandom_range(9))
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 15));
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3: start = 32'd0;
            4:          start = 32'hFFFF_FFFF;
            5:          start = $urandom;
            default:    start = 32'($urandom_range(1, 12));
         endcase
         write_config(pattern_word(), pattern_word(), care, len, start);

         repeat ($urandom_range(2, 4)) begin
            blen = ($urandom_range(4) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
            send_buffer(blen, $urandom_range(9) < 7);
         end
      end
      wait_idle();

      $display("run covered %0d bytes in %0d buffers under %0d register settings",
               bytes_sent, buffers_sent, settings_used);
      $display("%0d rsp beats compared, %0d of them matches", checked, match_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
